FILE: src/krgc_pkg.sv
// Shared types and constants for the key repeat grid cursor block.
package krgc_pkg;

  localparam int unsigned BUTTON_COUNT = 8;
  localparam int unsigned BUTTON_W = 8;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned BTN_LEFT = 0;
  localparam int unsigned BTN_RIGHT = 1;
  localparam int unsigned BTN_UP = 2;
  localparam int unsigned BTN_DOWN = 3;
  localparam int unsigned BTN_ENTER = 4;

  localparam logic [2:0] REG_MAX_COLUMN = 3'd0;
  localparam logic [2:0] REG_MAX_ROW = 3'd1;
  localparam logic [2:0] REG_LAST_ROW_MAX_COLUMN = 3'd2;
  localparam logic [2:0] REG_VISIBLE_ROWS = 3'd3;
  localparam logic [2:0] REG_REPEAT_START = 3'd4;
  localparam logic [2:0] REG_REPEAT_GAP = 3'd5;

  localparam logic [DATA_W-1:0] VISIBLE_ROWS_RST = 8'd1;
  localparam logic [DATA_W-1:0] REPEAT_START_RST = 8'd10;
  localparam logic [DATA_W-1:0] REPEAT_GAP_RST = 8'd1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_UP,
    CMD_DOWN,
    CMD_ENTER
  } krgc_cmd_e;

  typedef struct packed {
    logic [DATA_W-1:0] max_column;
    logic [DATA_W-1:0] max_row;
    logic [DATA_W-1:0] last_row_max_column;
    logic [DATA_W-1:0] visible_rows;
    logic [DATA_W-1:0] repeat_start;
    logic [DATA_W-1:0] repeat_gap;
  } krgc_cfg_t;

endpackage

FILE: src/krgc_regs.sv
// APB configuration register file.
module krgc_regs import krgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output krgc_cfg_t         cfg_o
);

  krgc_cfg_t cfg_q;
  logic [2:0] idx;
  logic wr_en;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;

  assign pready = 1'b1;
  assign idx = paddr[APB_AW-1:2];
  assign wr_en = psel & penable & pwrite & pready;
  assign wdata = pwdata[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_column <= '0;
      cfg_q.max_row <= '0;
      cfg_q.last_row_max_column <= '0;
      cfg_q.visible_rows <= VISIBLE_ROWS_RST;
      cfg_q.repeat_start <= REPEAT_START_RST;
      cfg_q.repeat_gap <= REPEAT_GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_COLUMN:          cfg_q.max_column <= wdata;
        REG_MAX_ROW:             cfg_q.max_row <= wdata;
        REG_LAST_ROW_MAX_COLUMN: cfg_q.last_row_max_column <= wdata;
        REG_VISIBLE_ROWS:        cfg_q.visible_rows <= wdata;
        REG_REPEAT_START:        cfg_q.repeat_start <= wdata;
        REG_REPEAT_GAP:          cfg_q.repeat_gap <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_COLUMN:          rdata = cfg_q.max_column;
      REG_MAX_ROW:             rdata = cfg_q.max_row;
      REG_LAST_ROW_MAX_COLUMN: rdata = cfg_q.last_row_max_column;
      REG_VISIBLE_ROWS:        rdata = cfg_q.visible_rows;
      REG_REPEAT_START:        rdata = cfg_q.repeat_start;
      REG_REPEAT_GAP:          rdata = cfg_q.repeat_gap;
      default:                 rdata = '0;
    endcase
  end

  assign prdata = APB_DW'(rdata);
  assign cfg_o = cfg_q;

endmodule

FILE: src/krgc_front.sv
// Front end: hold counters, auto repeat and click priority decode.
module krgc_front import krgc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  krgc_cfg_t           cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [BUTTON_W-1:0] held_buttons_i,
  input  logic [BUTTON_W-1:0] new_clicks_i,
  input  logic                full_i,
  output logic                push_o,
  output krgc_cmd_e           push_cmd_o
);

  logic [DATA_W-1:0] hold_q [BUTTON_COUNT];
  logic [DATA_W-1:0] hold_d [BUTTON_COUNT];
  logic [DATA_W-1:0] gap_q, gap_d;
  logic [BUTTON_COUNT-1:0] elig, lowest, rep;
  logic [BUTTON_W-1:0] clicks;
  logic accept;

  assign in_ready_o = ~full_i;
  assign accept = in_valid_i & ~full_i;

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (held_buttons_i[i]) begin
        hold_d[i] = (hold_q[i] == '1) ? hold_q[i] : hold_q[i] + 1'b1;
      end else begin
        hold_d[i] = '0;
      end
      elig[i] = held_buttons_i[i] && (hold_d[i] >= cfg_i.repeat_start);
    end
  end

  // a nonzero reload blocks repeats of higher buttons in the same tick
  assign lowest = elig & (~elig + 1'b1);

  always_comb begin
    if (gap_q != '0) begin
      rep = '0;
      gap_d = gap_q - 1'b1;
    end else if (cfg_i.repeat_gap == '0) begin
      rep = elig;
      gap_d = '0;
    end else begin
      rep = lowest;
      gap_d = (|elig) ? cfg_i.repeat_gap - 1'b1 : '0;
    end
  end

  assign clicks = new_clicks_i | BUTTON_W'(rep);

  always_comb begin
    priority if (clicks[BTN_LEFT])  push_cmd_o = CMD_LEFT;
    else if (clicks[BTN_RIGHT])     push_cmd_o = CMD_RIGHT;
    else if (clicks[BTN_UP])        push_cmd_o = CMD_UP;
    else if (clicks[BTN_DOWN])      push_cmd_o = CMD_DOWN;
    else if (clicks[BTN_ENTER])     push_cmd_o = CMD_ENTER;
    else                            push_cmd_o = CMD_NONE;
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        hold_q[i] <= '0;
      end
      gap_q <= '0;
    end else if (accept) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        hold_q[i] <= hold_d[i];
      end
      gap_q <= gap_d;
    end
  end

endmodule

FILE: src/krgc_queue.sv
// Two-entry command queue between front and back end.
module krgc_queue import krgc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  krgc_cmd_e push_cmd_i,
  input  logic      pop_i,
  output krgc_cmd_e pop_cmd_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW = $clog2(Depth);

  krgc_cmd_e mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == (PtrW+1)'(Depth));
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/krgc_back.sv
// Back end: cursor, wrap, clamp and scroll update with output register.
module krgc_back import krgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  krgc_cfg_t         cfg_i,
  input  logic              empty_i,
  input  krgc_cmd_e         cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] cursor_column_o,
  output logic [DATA_W-1:0] cursor_row_o,
  output logic [DATA_W-1:0] window_top_row_o,
  output logic              enter_selected_o
);

  logic [DATA_W-1:0] col_q, row_q, top_q;
  logic [DATA_W-1:0] col_d, row_d, top_d;
  logic [DATA_W-1:0] up_row, down_row, down_dist;
  logic valid_q, enter_q, enter_d;

  assign pop_o = ~empty_i & (~valid_q | out_ready_i);

  assign up_row = row_q - 1'b1;
  assign down_row = row_q + 1'b1;
  assign down_dist = down_row - top_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    top_d = top_q;
    enter_d = 1'b0;
    unique case (cmd_i)
      CMD_LEFT: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (row_q != '0) begin
          col_d = cfg_i.max_column;
          row_d = up_row;
          if (top_q > up_row) top_d = top_q - 1'b1;
        end
      end
      CMD_RIGHT: begin
        if (col_q < cfg_i.max_column) begin
          col_d = col_q + 1'b1;
          if (row_q == cfg_i.max_row && col_d > cfg_i.last_row_max_column) begin
            col_d = cfg_i.last_row_max_column;
          end
        end else if (row_q < cfg_i.max_row) begin
          col_d = '0;
          row_d = down_row;
          if (down_dist >= cfg_i.visible_rows) top_d = top_q + 1'b1;
        end
      end
      CMD_UP: begin
        if (row_q != '0) begin
          row_d = up_row;
          if (top_q > up_row) top_d = top_q - 1'b1;
        end
      end
      CMD_DOWN: begin
        if (row_q < cfg_i.max_row) begin
          row_d = down_row;
          if (down_dist >= cfg_i.visible_rows) top_d = top_q + 1'b1;
          if (down_row == cfg_i.max_row && col_q > cfg_i.last_row_max_column) begin
            col_d = cfg_i.last_row_max_column;
          end
        end
      end
      CMD_ENTER: enter_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      top_q <= '0;
      enter_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        col_q <= col_d;
        row_q <= row_d;
        top_q <= top_d;
        enter_q <= enter_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign cursor_column_o = col_q;
  assign cursor_row_o = row_q;
  assign window_top_row_o = top_q;
  assign enter_selected_o = enter_q;

endmodule

FILE: src/key_repeat_grid_cursor_core.sv
// Top level of the key repeat grid cursor block.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word per tick: the held
//   button vector and the newly clicked vector. Output channel
//   (out_valid_o/out_ready_i) returns one word per input word: cursor column,
//   row, window top row and the enter flag.
//   The front end updates the hold counters and repeat gap and reduces the
//   merged clicks to one cursor command; a two-entry queue feeds the back end,
//   which updates the cursor and holds the result in the output register.
//   An accepted word passes through the queue and then the output register.
//   Throughput: one word per cycle while the receiver takes every word.
//   A stalled receiver holds the output word; the queue behind it then fills
//   and in_ready_o drops once it holds two words.
//   Reset clears counters, cursor and window, and sets the registers to
//   their defaults. Registers sit on the APB port at byte address 4*index;
//   it is up to the user to write them only while no word is in flight.
module key_repeat_grid_cursor_core import krgc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [BUTTON_W-1:0] held_buttons_i,
  input  logic [BUTTON_W-1:0] new_clicks_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DATA_W-1:0]   cursor_column_o,
  output logic [DATA_W-1:0]   cursor_row_o,
  output logic [DATA_W-1:0]   window_top_row_o,
  output logic                enter_selected_o
);

  krgc_cfg_t cfg;
  krgc_cmd_e push_cmd, pop_cmd;
  logic push, pop, empty, full;

  krgc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  krgc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .held_buttons_i (held_buttons_i),
    .new_clicks_i   (new_clicks_i),
    .full_i         (full),
    .push_o         (push),
    .push_cmd_o     (push_cmd)
  );

  krgc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty),
    .full_o     (full)
  );

  krgc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .empty_i          (empty),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .window_top_row_o (window_top_row_o),
    .enter_selected_o (enter_selected_o)
  );

endmodule
